>>> rtl/core/preamble_parity_serial_transmitter_top_defines.svh
// Assertion macros for the preamble/parity serial transmitter
`ifndef PREAMBLE_PARITY_SERIAL_TRANSMITTER_TOP_DEFINES_SVH
`define PREAMBLE_PARITY_SERIAL_TRANSMITTER_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low
`define PPST_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low
`define PPST_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/ppst_pkg.sv
// Shared types and constants for the preamble/parity serial transmitter
`default_nettype none
package ppst_pkg;

  localparam int PERIOD_W = 16;
  localparam int DATA_W   = 8;
  localparam int STEP_W   = 4;

  localparam logic [PERIOD_W-1:0] SHORT_PERIOD_RST = 16'd1000;
  localparam logic [PERIOD_W-1:0] LONG_PERIOD_RST  = 16'd10000;

  // register indexes on the config port
  localparam logic CFG_SHORT_PERIOD = 1'b0;
  localparam logic CFG_LONG_PERIOD  = 1'b1;

  // frame step codes
  localparam logic [STEP_W-1:0] STEP_LOW_A      = 4'd1;
  localparam logic [STEP_W-1:0] STEP_HIGH       = 4'd2;
  localparam logic [STEP_W-1:0] STEP_LOW_B      = 4'd3;
  localparam logic [STEP_W-1:0] STEP_DATA_FIRST = 4'd4;
  localparam logic [STEP_W-1:0] STEP_DATA_LAST  = 4'd11;
  localparam logic [STEP_W-1:0] STEP_PARITY     = 4'd12;
  localparam logic [STEP_W-1:0] STEP_END        = 4'd13;
  localparam logic [STEP_W-1:0] STEP_IDLE       = 4'd0;

  typedef struct packed {
    logic              load;
    logic [DATA_W-1:0] data;
  } item_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic accepted;
    logic frame_done;
  } result_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

endpackage
`default_nettype wire

>>> rtl/core/preamble_parity_serial_transmitter_top.sv
// Top level of the preamble/parity serial transmitter
// Usage:
//   Each input item is one timer tick (in_kind = 0) or a tick that also
//   loads in_data_byte (in_kind = 1). A load is taken only while idle.
//   A frame drives the line high, then low/high/low preamble steps of
//   short_period ticks each, eight data bits LSB first and an even parity
//   bit of long_period ticks each, then the line drops and out_frame_done
//   pulses. A load while busy reports out_accepted = 0.
//   Every input item gives exactly one result item on the out_ channel.
// Path: an accepted item passes the queue register, then the result
//   register behind the sequencer, which raises out_valid.
// Throughput: one item per cycle while out_ready is high; the sequencer
//   step is a single increment-and-compare on the tick counter.
// Stalls: a two-entry queue sits between intake and sequencer, and the
//   result register holds while out_ready is low; in_ready drops only when
//   the queue is full.
// Config: cfg_we writes short_period (index 0) or long_period (index 1);
//   write only while idle.
// Reset: synchronous active-low rst_n empties the queue, clears the
//   result stage, idles the sequencer with the line low and restores the
//   period registers to 1000 and 10000 ticks.
`default_nettype none
`include "preamble_parity_serial_transmitter_top_defines.svh"
module preamble_parity_serial_transmitter_top import ppst_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                in_kind,
  input  wire logic [DATA_W-1:0]   in_data_byte,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     out_line_level,
  output logic                     out_busy_res,
  output logic                     out_accepted,
  output logic                     out_frame_done,
  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic [PERIOD_W-1:0] cfg_wdata
);

  logic [PERIOD_W-1:0] short_period_r, short_period_nxt;
  logic [PERIOD_W-1:0] long_period_r, long_period_nxt;
  queue_head_t         head;
  logic                pop;
  result_t             res;

  // config registers; a period of zero behaves as one tick in the sequencer
  always_comb begin
    short_period_nxt = short_period_r;
    long_period_nxt  = long_period_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_SHORT_PERIOD: short_period_nxt = cfg_wdata;
        CFG_LONG_PERIOD:  long_period_nxt  = cfg_wdata;
        default:          short_period_nxt = short_period_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_period_r <= SHORT_PERIOD_RST;
      long_period_r  <= LONG_PERIOD_RST;
    end else begin
      short_period_r <= short_period_nxt;
      long_period_r  <= long_period_nxt;
    end
  end

  ppst_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_kind      (in_kind),
    .in_data_byte (in_data_byte),
    .head         (head),
    .pop          (pop)
  );

  ppst_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head         (head),
    .pop          (pop),
    .short_period (short_period_r),
    .long_period  (long_period_r),
    .res_valid    (out_valid),
    .res          (res),
    .res_ready    (out_ready)
  );

  assign out_line_level = res.line_level;
  assign out_busy_res   = res.busy_res;
  assign out_accepted   = res.accepted;
  assign out_frame_done = res.frame_done;

  // a taken load starts a frame with the line high
  `PPST_ASSERT_IMP(a_load_starts_high, out_valid && out_accepted, out_busy_res && out_line_level, "load result not busy/high")
  // frame end leaves the block idle with the line low
  `PPST_ASSERT_IMP(a_done_idles, out_valid && out_frame_done, !out_busy_res && !out_line_level && !out_accepted, "frame end not idle")
  // an idle line is always low
  `PPST_ASSERT_IMP(a_idle_low, out_valid && !out_busy_res, !out_line_level, "line high while idle")
  // the sequencer never consumes a queued item while the result stage is stalled
  `PPST_ASSERT_NXT(a_stall_no_pop, out_valid && !out_ready, !(pop && $past(pop)) || out_valid, "pop during stall")

endmodule
`default_nettype wire

>>> rtl/core/ppst_front.sv
// Front end: takes items, classifies load vs tick, two-entry queue
`default_nettype none
module ppst_front import ppst_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_kind,
  input  wire logic [DATA_W-1:0] in_data_byte,
  output queue_head_t            head,
  input  wire logic              pop
);

  item_t      mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push, do_pop;

  assign in_ready = (count_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign do_pop   = pop && (count_r != 2'd0);

  assign head.valid = (count_r != 2'd0);
  assign head.item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push   ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= '{load: in_kind, data: in_data_byte};
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/ppst_back.sv
// Back end: frame sequencer plus registered result stage
`default_nettype none
module ppst_back import ppst_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire queue_head_t         head,
  output logic                     pop,
  input  wire logic [PERIOD_W-1:0] short_period,
  input  wire logic [PERIOD_W-1:0] long_period,
  output logic                     res_valid,
  output result_t                  res,
  input  wire logic                res_ready
);

  logic                sending_r, sending_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [PERIOD_W-1:0] tick_r, tick_nxt;
  logic [DATA_W-1:0]   shift_r, shift_nxt;
  logic                parity_r, parity_nxt;
  logic                line_r, line_nxt;
  logic                out_valid_r, out_valid_nxt;
  result_t             res_r, res_nxt;

  logic [PERIOD_W-1:0] period;
  logic [PERIOD_W:0]   cnt;
  logic [STEP_W-1:0]   step_inc;

  assign pop       = head.valid && (!out_valid_r || res_ready);
  assign res_valid = out_valid_r;
  assign res       = res_r;

  assign period   = (step_r < STEP_DATA_FIRST) ? short_period : long_period;
  assign cnt      = {1'b0, tick_r} + {{PERIOD_W{1'b0}}, 1'b1};
  assign step_inc = step_r + 4'd1;

  always_comb begin
    sending_nxt = sending_r;
    step_nxt    = step_r;
    tick_nxt    = tick_r;
    shift_nxt   = shift_r;
    parity_nxt  = parity_r;
    line_nxt    = line_r;
    res_nxt     = res_r;
    if (pop) begin
      res_nxt.accepted   = 1'b0;
      res_nxt.frame_done = 1'b0;
      if (sending_r) begin
        if (cnt >= {1'b0, period}) begin
          tick_nxt = '0;
          step_nxt = step_inc;
          if (step_inc <= STEP_LOW_B) begin
            line_nxt = (step_inc == STEP_HIGH);
          end else if (step_inc <= STEP_DATA_LAST) begin
            line_nxt   = shift_r[0];
            parity_nxt = parity_r ^ shift_r[0];
            shift_nxt  = {1'b0, shift_r[DATA_W-1:1]};
          end else if (step_inc == STEP_PARITY) begin
            line_nxt = parity_r;
          end else begin
            line_nxt           = 1'b0;
            sending_nxt        = 1'b0;
            step_nxt           = STEP_IDLE;
            res_nxt.frame_done = 1'b1;
          end
        end else begin
          tick_nxt = cnt[PERIOD_W-1:0];
        end
      end else if (head.item.load) begin
        sending_nxt      = 1'b1;
        step_nxt         = STEP_IDLE;
        tick_nxt         = '0;
        shift_nxt        = head.item.data;
        parity_nxt       = 1'b0;
        line_nxt         = 1'b1;
        res_nxt.accepted = 1'b1;
      end
      res_nxt.line_level = line_nxt;
      res_nxt.busy_res   = sending_nxt;
    end
    out_valid_nxt = pop ? 1'b1 : (out_valid_r && !res_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sending_r   <= 1'b0;
      step_r      <= STEP_IDLE;
      tick_r      <= '0;
      shift_r     <= '0;
      parity_r    <= 1'b0;
      line_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sending_r   <= sending_nxt;
      step_r      <= step_nxt;
      tick_r      <= tick_nxt;
      shift_r     <= shift_nxt;
      parity_r    <= parity_nxt;
      line_r      <= line_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= '0;
    end else begin
      res_r <= res_nxt;
    end
  end

endmodule
`default_nettype wire
